@@ hw/rtl/rud_pkg.sv @@
package rud_pkg;

  // Iteration limit default
  localparam int unsigned IterLimitDefault = 20;

  // Divider widths: 60-bit magnitude dividend, 32-bit divisor, 32-bit quotient
  localparam int unsigned NumW = 60;
  localparam int unsigned DenW = 32;
  localparam int unsigned QuoW = 32;

  // Register reset values
  localparam logic [23:0] FocalReset = 24'd256000;
  localparam logic [15:0] TolReset   = 16'd10;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FOCAL = 2'd0,
    REG_K1    = 2'd1,
    REG_K2    = 2'd2,
    REG_TOL   = 2'd3
  } cfg_reg_e;

  // Divide request into the cell row
  typedef struct packed {
    logic            vld;
    logic            tag_y;
    logic            neg;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  // Saturated signed quotient out of the row
  typedef struct packed {
    logic                   vld;
    logic                   tag_y;
    logic signed [QuoW-1:0] quo;
  } div_rsp_t;

  // What one cell hands to the next
  typedef struct packed {
    logic            vld;
    logic            tag_y;
    logic            neg;
    logic            sat;
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] lo;
    logic [DenW-1:0] den;
  } div_cell_t;

endpackage

@@ hw/rtl/rud_div_cell.sv @@
module rud_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rud_pkg::div_cell_t  cell_i,
  output rud_pkg::div_cell_t  cell_o
);

  logic [rud_pkg::DenW:0] shifted;
  logic [rud_pkg::DenW:0] diff;
  logic                   ge;
  rud_pkg::div_cell_t     cell_d;
  rud_pkg::div_cell_t     data_q;
  logic                   vld_q;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted     = {cell_i.rem, cell_i.lo[rud_pkg::QuoW-1]};
    ge          = shifted >= {1'b0, cell_i.den};
    diff        = shifted - {1'b0, cell_i.den};
    cell_d      = cell_i;
    cell_d.rem  = ge ? diff[rud_pkg::DenW-1:0] : shifted[rud_pkg::DenW-1:0];
    cell_d.lo   = {cell_i.lo[rud_pkg::QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= cell_d;
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

@@ hw/rtl/rud_divider.sv @@
module rud_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rud_pkg::div_req_t  req_i,
  output rud_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned HiW = rud_pkg::NumW - rud_pkg::QuoW;

  rud_pkg::div_cell_t chain [rud_pkg::QuoW+1];
  logic [rud_pkg::DenW-1:0] hi;
  logic [rud_pkg::QuoW-1:0] mag;
  rud_pkg::div_cell_t       last;

  // Entry: upper dividend part seeds the remainder, overflow flags saturation
  always_comb begin
    hi             = {{(rud_pkg::DenW-HiW){1'b0}}, req_i.num[rud_pkg::NumW-1:rud_pkg::QuoW]};
    chain[0].vld   = req_i.vld;
    chain[0].tag_y = req_i.tag_y;
    chain[0].neg   = req_i.neg;
    chain[0].sat   = hi >= req_i.den;
    chain[0].rem   = hi;
    chain[0].lo    = req_i.num[rud_pkg::QuoW-1:0];
    chain[0].den   = req_i.den;
  end

  // Row of cells, one quotient bit per cell, MSB first
  for (genvar g = 0; g < rud_pkg::QuoW; g++) begin : g_cell
    rud_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // Exit: apply sign and saturate to the signed 32-bit range
  always_comb begin
    last        = chain[rud_pkg::QuoW];
    mag         = last.lo;
    rsp_o.vld   = last.vld;
    rsp_o.tag_y = last.tag_y;
    if (last.sat) begin
      rsp_o.quo = last.neg ? {1'b1, {(rud_pkg::QuoW-1){1'b0}}}
                           : {1'b0, {(rud_pkg::QuoW-1){1'b1}}};
    end else if (!last.neg) begin
      rsp_o.quo = mag[rud_pkg::QuoW-1] ? {1'b0, {(rud_pkg::QuoW-1){1'b1}}} : mag;
    end else begin
      rsp_o.quo = (mag[rud_pkg::QuoW-1] && (|mag[rud_pkg::QuoW-2:0]))
                  ? {1'b1, {(rud_pkg::QuoW-1){1'b0}}} : (~mag + 1'b1);
    end
  end

endmodule

@@ hw/rtl/radial_undistort_fixed_point.sv @@
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  pixel_x_i, pixel_y_i
// out      output     out_valid_o/ out_ready_i norm_x_o, norm_y_o, converged_o, iterations_o
// cfg      input      cfg_valid_i/ cfg_ready_o cfg_index_i, cfg_data_i
//
// One word at a time. A word is done when the error check passes after n updates, or
// when the updates run out (no check follows the last one). Each update is an error check
// on the shared multiplier plus a pass through the 32-cell divider row; the start value
// also takes one divider pass. Reset restores the register defaults and empties the
// divider row. A new word is taken once the previous result sits in the output
// register; a stalled output holds the next result in the final state.
module radial_undistort_fixed_point #(
  parameter int unsigned ITER_LIMIT = rud_pkg::IterLimitDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] pixel_x_i,
  input  logic signed [23:0] pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] norm_x_o,
  output logic signed [31:0] norm_y_o,
  output logic               converged_o,
  output logic [4:0]         iterations_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam int IW = $clog2(ITER_LIMIT + 1);
  localparam int CW = (IW > 5) ? IW : 5;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UDIVX = 9'b000000010,
    S_UDIVY = 9'b000000100,
    S_UWAIT = 9'b000001000,
    S_CALC  = 9'b000010000,
    S_CDIVX = 9'b000100000,
    S_CDIVY = 9'b001000000,
    S_CWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  typedef enum logic [3:0] {
    STEP_SQX = 4'd0,
    STEP_SQY = 4'd1,
    STEP_KR  = 4'd2,
    STEP_TR  = 4'd3,
    STEP_DCX = 4'd4,
    STEP_QFX = 4'd5,
    STEP_DCY = 4'd6,
    STEP_QFY = 4'd7,
    STEP_EXX = 4'd8,
    STEP_EYY = 4'd9
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   phase_q, phase_d;

  // Configuration
  logic [23:0]        focal_q;
  logic signed [23:0] k1_q, k2_q;
  logic [15:0]        tol_q;
  logic [23:0]        feff;

  // Item working set
  logic signed [23:0] px_q, py_q;
  logic signed [31:0] ux_q, uy_q, cx_q, cy_q;
  logic [31:0]        r2x_q, r2_q, tol2_q;
  logic signed [32:0] t_q, d_q;
  logic signed [35:0] q_q;
  logic signed [31:0] ex_q, ey_q;
  logic [61:0]        ee_q;
  logic [CW-1:0]      it_q, it_inc;
  logic               conv_q;

  // Shared multiplier
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod_q;

  // Output register
  logic               out_valid_q, conv_out_q;
  logic signed [31:0] norm_x_q, norm_y_q;
  logic [4:0]         iter_out_q;
  logic               out_load;

  // Writeback arithmetic
  logic signed [40:0] tsum;
  logic signed [32:0] t_next;
  logic signed [49:0] dsum;
  logic signed [32:0] d_next;
  logic signed [35:0] pshift;
  logic signed [53:0] esum;
  logic signed [31:0] e_next;
  logic [61:0]        errsum;
  logic               pass;

  // Divider interface
  rud_pkg::div_req_t div_req;
  rud_pkg::div_rsp_t div_rsp;
  logic [23:0] abs_px, abs_py;
  logic [31:0] abs_ux, abs_uy, abs_d, den_d;
  logic [32:0] neg_d;

  assign feff        = (focal_q == 24'd0) ? 24'd1 : focal_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign it_inc      = it_q + CW'(1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= rud_pkg::FocalReset;
      k1_q    <= '0;
      k2_q    <= '0;
      tol_q   <= rud_pkg::TolReset;
    end else if (cfg_valid_i) begin
      unique case (rud_pkg::cfg_reg_e'(cfg_index_i))
        rud_pkg::REG_FOCAL: focal_q <= cfg_data_i;
        rud_pkg::REG_K1:    k1_q    <= cfg_data_i;
        rud_pkg::REG_K2:    k2_q    <= cfg_data_i;
        rud_pkg::REG_TOL:   tol_q   <= cfg_data_i[15:0];
      endcase
    end
  end

  // Multiplier operand select by step
  always_comb begin
    unique case (step_q)
      STEP_SQX: begin mul_a = 36'(cx_q); mul_b = 33'(cx_q); end
      STEP_SQY: begin mul_a = 36'(cy_q); mul_b = 33'(cy_q); end
      STEP_KR:  begin mul_a = 36'(k2_q); mul_b = {1'b0, r2_q}; end
      STEP_TR:  begin mul_a = 36'(t_q);  mul_b = {1'b0, r2_q}; end
      STEP_DCX: begin mul_a = 36'(d_q);  mul_b = 33'(cx_q); end
      STEP_QFX: begin mul_a = q_q;       mul_b = {9'd0, feff}; end
      STEP_DCY: begin mul_a = 36'(d_q);  mul_b = 33'(cy_q); end
      STEP_QFY: begin mul_a = q_q;       mul_b = {9'd0, feff}; end
      STEP_EXX: begin mul_a = 36'(ex_q); mul_b = 33'(ex_q); end
      STEP_EYY: begin mul_a = 36'(ey_q); mul_b = 33'(ey_q); end
      default:  begin mul_a = '0;        mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Writeback math: shifts, offsets and clamps on the registered product
  always_comb begin
    tsum = $signed({{13{k1_q[23]}}, k1_q, 4'b0}) + $signed(prod_q[60:20]);
    if (tsum > 41'sd2147483648) begin
      t_next = 33'sd2147483648;
    end else if (tsum < -41'sd2147483648) begin
      t_next = -33'sd2147483648;
    end else begin
      t_next = tsum[32:0];
    end

    dsum = 50'sd268435456 + $signed(prod_q[68:20]);
    if (dsum > 50'sd4294967295) begin
      d_next = 33'sd4294967295;
    end else if (dsum < -50'sd4294967295) begin
      d_next = -33'sd4294967295;
    end else begin
      d_next = dsum[32:0];
    end

    pshift = (step_q == STEP_QFX) ? $signed({px_q, 12'b0}) : $signed({py_q, 12'b0});
    esum   = $signed(prod_q[68:16]) - pshift;
    if (esum > 54'sd1073741824) begin
      e_next = 32'sd1073741824;
    end else if (esum < -54'sd1073741824) begin
      e_next = -32'sd1073741824;
    end else begin
      e_next = esum[31:0];
    end

    errsum = ee_q + prod_q[61:0];
    pass   = errsum < {30'd0, tol2_q};
  end

  // Divider requests
  always_comb begin
    abs_px  = px_q[23] ? (~px_q + 24'd1) : px_q;
    abs_py  = py_q[23] ? (~py_q + 24'd1) : py_q;
    abs_ux  = ux_q[31] ? (~ux_q + 32'd1) : ux_q;
    abs_uy  = uy_q[31] ? (~uy_q + 32'd1) : uy_q;
    neg_d   = ~d_q + 33'd1;
    abs_d   = d_q[32] ? neg_d[31:0] : d_q[31:0];
    den_d   = (d_q == 33'sd0) ? 32'd1 : abs_d;
    div_req = '0;
    unique case (state_q)
      S_UDIVX: begin
        div_req.vld = 1'b1;
        div_req.neg = px_q[23];
        div_req.num = {8'd0, abs_px, 28'd0};
        div_req.den = {8'd0, feff};
      end
      S_UDIVY: begin
        div_req.vld   = 1'b1;
        div_req.tag_y = 1'b1;
        div_req.neg   = py_q[23];
        div_req.num   = {8'd0, abs_py, 28'd0};
        div_req.den   = {8'd0, feff};
      end
      S_CDIVX: begin
        div_req.vld = 1'b1;
        div_req.neg = ux_q[31] ^ d_q[32];
        div_req.num = {abs_ux, 28'd0};
        div_req.den = den_d;
      end
      S_CDIVY: begin
        div_req.vld   = 1'b1;
        div_req.tag_y = 1'b1;
        div_req.neg   = uy_q[31] ^ d_q[32];
        div_req.num   = {abs_uy, 28'd0};
        div_req.den   = den_d;
      end
      default: div_req = '0;
    endcase
  end

  rud_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    phase_d  = phase_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_UDIVX;
      S_UDIVX: state_d = S_UDIVY;
      S_UDIVY: state_d = S_UWAIT;
      S_UWAIT: begin
        if (div_rsp.vld && div_rsp.tag_y) begin
          state_d = S_CALC;
          step_d  = STEP_SQX;
          phase_d = 1'b0;
        end
      end
      S_CALC: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          if (step_q == STEP_EYY) begin
            state_d = pass ? S_DONE : S_CDIVX;
          end else begin
            step_d = step_e'(step_q + 4'd1);
          end
        end
      end
      S_CDIVX: state_d = S_CDIVY;
      S_CDIVY: state_d = S_CWAIT;
      S_CWAIT: begin
        if (div_rsp.vld && div_rsp.tag_y) begin
          state_d = (it_inc == CW'(ITER_LIMIT)) ? S_DONE : S_CALC;
          step_d  = STEP_SQX;
          phase_d = 1'b0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_SQX;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      tol2_q <= 32'(tol_q) * 32'(tol_q);
      it_q   <= '0;
      conv_q <= 1'b0;
    end
    // Quotients land in the current estimate; the first pair is also the start value
    if (div_rsp.vld) begin
      if (div_rsp.tag_y) begin
        cy_q <= div_rsp.quo;
        if (state_q == S_UWAIT) uy_q <= div_rsp.quo;
      end else begin
        cx_q <= div_rsp.quo;
        if (state_q == S_UWAIT) ux_q <= div_rsp.quo;
      end
    end
    if (state_q == S_CWAIT && div_rsp.vld && div_rsp.tag_y) begin
      it_q <= it_inc;
    end
    if (state_q == S_CALC && phase_q) begin
      unique case (step_q)
        STEP_SQX: r2x_q <= prod_q[63:32];
        STEP_SQY: r2_q  <= r2x_q + prod_q[63:32];
        STEP_KR:  t_q   <= t_next;
        STEP_TR:  d_q   <= d_next;
        STEP_DCX: q_q   <= prod_q[63:28];
        STEP_QFX: ex_q  <= e_next;
        STEP_DCY: q_q   <= prod_q[63:28];
        STEP_QFY: ey_q  <= e_next;
        STEP_EXX: ee_q  <= prod_q[61:0];
        STEP_EYY: conv_q <= pass;
        default:  ee_q  <= ee_q;
      endcase
    end
    if (out_load) begin
      norm_x_q   <= cx_q;
      norm_y_q   <= cy_q;
      conv_out_q <= conv_q;
      iter_out_q <= (it_q > CW'(31)) ? 5'd31 : it_q[4:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign norm_x_o     = norm_x_q;
  assign norm_y_o     = norm_y_q;
  assign converged_o  = conv_out_q;
  assign iterations_o = iter_out_q;

  // Checks
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |-> step_q <= STEP_EYY)
    else $error("step counter out of range");

  a_rsp_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.vld |-> (state_q == S_UWAIT || state_q == S_CWAIT))
    else $error("divider result outside a wait state");

  a_noconv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converged_o |->
      iterations_o == ((ITER_LIMIT > 31) ? 5'd31 : 5'(ITER_LIMIT)))
    else $error("unconverged result without full iteration count");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result shown without finishing");

endmodule

@@ tb/sv/radial_undistort_fixed_point_test.sv @@
module radial_undistort_fixed_point_test;

  localparam int unsigned IterLimit = rud_pkg::IterLimitDefault;
  localparam int          IdleLimit = 20000;
  localparam int          LongHold  = 400;
  localparam int          DrainWait = 1200;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
  } pixel_t;

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic               conv;
    logic [4:0]         iters;
  } undist_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] pixel_x_i = '0;
  logic signed [23:0] pixel_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] norm_x_o;
  logic signed [31:0] norm_y_o;
  logic               converged_o;
  logic [4:0]         iterations_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;

  radial_undistort_fixed_point dut (.*);

  always #5 clk_i = ~clk_i;

  // Local copy of the configuration registers
  logic        [23:0] focal_q = rud_pkg::FocalReset;
  logic signed [23:0] k1_q = '0;
  logic signed [23:0] k2_q = '0;
  logic        [15:0] tol_q = rud_pkg::TolReset;

  pixel_t  pixel_q[$];
  undist_t norm_q[$];
  int      errors = 0;
  int      cfg_writes = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  bit      in_fire = 1'b0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // d = 1 + k1*r2 + k2*r2^2 in Q28
  function automatic longint radial_gain(longint x, longint y);
    longint r2, t, k1, k2;
    k1 = k1_q;
    k2 = k2_q;
    r2 = ((x * x) >>> 32) + ((y * y) >>> 32);
    t  = clamp(k1 * 16 + ((k2 * r2) >>> 20), -(64'sd1 <<< 31), 64'sd1 <<< 31);
    return clamp((64'sd1 <<< 28) + ((t * r2) >>> 20),
                 -((64'sd1 <<< 32) - 1), (64'sd1 <<< 32) - 1);
  endfunction

  // Reprojection error of one axis in Q12 pixels
  function automatic longint reproj_err(longint d, longint c, longint pix, longint f);
    longint q, e;
    q = (d * c) >>> 28;
    e = ((q * f) >>> 16) - pix * 4096;
    return clamp(e, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  function automatic undist_t undistort(pixel_t p);
    longint  px, py, f, ux, uy, cx, cy, d, ex, ey, tol2;
    int      n;
    bit      ok;
    undist_t r;
    px = p.px;
    py = p.py;
    f  = (focal_q == 0) ? 1 : longint'(focal_q);
    ux = sat32(px * 268435456 / f);
    uy = sat32(py * 268435456 / f);
    cx = ux;
    cy = uy;
    tol2 = longint'(tol_q) * longint'(tol_q);
    ok = 1'b0;
    for (n = 0; n < IterLimit; n++) begin
      d  = radial_gain(cx, cy);
      ex = reproj_err(d, cx, px, f);
      ey = reproj_err(d, cy, py, f);
      if (ex * ex + ey * ey < tol2) begin
        ok = 1'b1;
        break;
      end
      if (d == 0) d = 1;
      cx = sat32(ux * 268435456 / d);
      cy = sat32(uy * 268435456 / d);
    end
    r.nx = cx[31:0];
    r.ny = cy[31:0];
    r.conv = ok;
    r.iters = (n > 31) ? 5'd31 : n[4:0];
    return r;
  endfunction

  // Scoreboard, config tracking and watchdog
  always @(posedge clk_i) begin
    undist_t e;
    in_fire <= in_valid_i && in_ready_o;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h conv=%b it=%0d", $time,
                   norm_x_o, norm_y_o, converged_o, iterations_o);
          errors++;
        end else begin
          e = norm_q.pop_front();
          if (norm_x_o !== e.nx || norm_y_o !== e.ny || converged_o !== e.conv ||
              iterations_o !== e.iters) begin
            $display("%0t: mismatch exp x=%h y=%h conv=%b it=%0d", $time,
                     e.nx, e.ny, e.conv, e.iters);
            $display("%0t:          got x=%h y=%h conv=%b it=%0d", $time,
                     norm_x_o, norm_y_o, converged_o, iterations_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o)
        norm_q.push_back(undistort('{pixel_x_i, pixel_y_i}));
      if (cfg_valid_i && cfg_ready_o) begin
        case (rud_pkg::cfg_reg_e'(cfg_index_i))
          rud_pkg::REG_FOCAL: focal_q = cfg_data_i;
          rud_pkg::REG_K1:    k1_q = cfg_data_i;
          rud_pkg::REG_K2:    k2_q = cfg_data_i;
          rud_pkg::REG_TOL:   tol_q = cfg_data_i[15:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, IdleLimit);
        $display("** radial_undistort_fixed_point: FAILED **");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Input driver: next word once the current one is taken
  always @(negedge clk_i) begin
    pixel_t p;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pixel_q.pop_front();
        pixel_x_i <= p.px;
        pixel_y_i <= p.py;
        in_valid_i <= 1'b1;
      end else
        in_valid_i <= 1'b0;
    end
  end

  // Output ready: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    int hold_cnt;
    if (hold_req && !hold_done && hold_cnt == 0) hold_cnt = LongHold;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_done = 1'b1;
      out_ready_i <= 1'b0;
    end else
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic cfg_write(rud_pkg::cfg_reg_e idx, logic [23:0] data);
    int n0;
    n0 = cfg_writes;
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (cfg_writes == n0);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic cfg_all(logic [23:0] f, logic [23:0] k1, logic [23:0] k2, logic [15:0] tol);
    cfg_write(rud_pkg::REG_FOCAL, f);
    cfg_write(rud_pkg::REG_K1, k1);
    cfg_write(rud_pkg::REG_K2, k2);
    cfg_write(rud_pkg::REG_TOL, {8'h00, tol});
  endtask

  // Checked at the rising edge, where the driver's queue and valid are settled
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || norm_q.size() != 0);
  endtask

  task automatic push_pixel(logic [23:0] x, logic [23:0] y);
    pixel_q.push_back('{x, y});
  endtask

  // Mostly points inside the frame, some full range
  task automatic push_random(int n);
    int lim;
    lim = (focal_q > 24'd8388607) ? 8388607 : int'(focal_q);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80)
        push_pixel(24'($urandom_range(2 * lim) - lim), 24'($urandom_range(2 * lim) - lim));
      else
        push_pixel(24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, field extremes
    send_idle_pct = 32;
    recv_idle_pct = 80;
    push_pixel(24'h000000, 24'h000000);
    push_pixel(24'h7FFFFF, 24'h7FFFFF);
    push_pixel(24'h800000, 24'h800000);
    push_pixel(24'h7FFFFF, 24'h800000);
    push_pixel(24'hFFFFFF, 24'h000001);
    push_pixel(24'h03E800, 24'hFC1800);
    wait_idle();

    // Zero focal length, zero tolerance, extreme coefficients
    cfg_all(24'h000000, 24'h800000, 24'h7FFFFF, 16'h0000);
    push_pixel(24'h000000, 24'h000000);
    push_pixel(24'h7FFFFF, 24'h800000);
    push_pixel(24'h000100, 24'hFFFF00);
    push_pixel(24'h000001, 24'h000001);
    wait_idle();
    cfg_all(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF);
    push_pixel(24'h000000, 24'h000000);
    push_pixel(24'h7FFFFF, 24'h7FFFFF);
    push_pixel(24'h800000, 24'h800000);
    push_pixel(24'h400000, 24'hC00000);
    wait_idle();
    // Strong barrel distortion, divisor can cross zero
    cfg_all(24'd65536, 24'hF00000, 24'h000000, 16'd100);
    push_pixel(24'h7FFFFF, 24'h7FFFFF);
    push_pixel(24'h010000, 24'h000000);
    push_pixel(24'h020000, 24'h018000);
    wait_idle();

    // Random: several realistic settings, three idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 80 : 0;
      recv_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 32 : 0;
      cfg_all(24'($urandom_range(400000, 50000)), 24'($urandom_range(600000) - 300000),
              24'($urandom_range(200000) - 100000), 16'($urandom_range(2000, 5)));
      if (ph == 4) hold_req = 1'b1;
      push_random(120);
      wait_idle();
    end
    cfg_all(rud_pkg::FocalReset, 24'h000000, 24'h000000, rud_pkg::TolReset);
    push_random(20);
    wait_idle();

    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0 && norm_q.size() == 0)
      $display("** radial_undistort_fixed_point: PASSED **");
    else
      $display("** radial_undistort_fixed_point: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rud_pkg.sv
hw/rtl/rud_div_cell.sv
hw/rtl/rud_divider.sv
hw/rtl/radial_undistort_fixed_point.sv
tb/sv/radial_undistort_fixed_point_test.sv
